// File: src/usp_pkg.sv
// Shared constants, types and helper functions for the URL span parser.
package usp_pkg;

    localparam int MAX_LEN    = 256;
    localparam int POS_W      = $clog2(MAX_LEN + 1);
    localparam int SPAN_COUNT = 5;
    localparam int START_W    = 8;
    localparam int LEN_W      = 9;
    localparam int KIND_W     = 3;
    localparam int WIDE_W     = POS_W + LEN_W + START_W;

    localparam logic [KIND_W-1:0] K_PROTOCOL = KIND_W'(0);
    localparam logic [KIND_W-1:0] K_USERINFO = KIND_W'(1);
    localparam logic [KIND_W-1:0] K_HOST     = KIND_W'(2);
    localparam logic [KIND_W-1:0] K_PORT     = KIND_W'(3);
    localparam logic [KIND_W-1:0] K_RESOURCE = KIND_W'(4);
    localparam logic [KIND_W-1:0] K_STATUS   = KIND_W'(5);

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        MODE_SCHEME,
        MODE_COLON,
        MODE_SLASH,
        MODE_AUTH,
        MODE_PORT,
        MODE_PATH,
        MODE_HALT
    } mode_t;

    typedef logic [POS_W-1:0] pos_t;

    // Finished parse handed from the parser to the output stage.
    typedef struct packed {
        logic [SPAN_COUNT-1:0]              present;
        logic [SPAN_COUNT-1:0][START_W-1:0] start;
        logic [SPAN_COUNT-1:0][LEN_W-1:0]   length;
        logic                               ok;
    } span_set_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return is_digit(c) || ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic pos_t span_len(input pos_t first, input pos_t stop);
        return (stop >= first) ? pos_t'(stop - first) : '0;
    endfunction

    function automatic logic [START_W-1:0] to_start(input pos_t v);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        return w[START_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] to_len(input pos_t v);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        return w[LEN_W-1:0];
    endfunction

endpackage

// File: src/usp_core.sv
// Per-byte parse step: mode, position and span registers.
module usp_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  logic [7:0]       text_byte,
    input  logic             end_of_text,
    output usp_pkg::span_set_t snap
);

    usp_pkg::mode_t mode_reg, mode_next;
    usp_pkg::pos_t  pos_reg, pos_next;
    usp_pkg::pos_t  run_reg, run_next;
    usp_pkg::pos_t  start_reg [usp_pkg::SPAN_COUNT];
    usp_pkg::pos_t  start_next [usp_pkg::SPAN_COUNT];
    usp_pkg::pos_t  len_reg [usp_pkg::SPAN_COUNT];
    usp_pkg::pos_t  len_next [usp_pkg::SPAN_COUNT];
    logic [usp_pkg::SPAN_COUNT-1:0] pres_reg, pres_next;
    logic failed_reg, failed_next;

    logic          do_auth, do_port, do_path, do_fail;
    usp_pkg::pos_t pos_inc, pos_dec;

    assign pos_inc = usp_pkg::pos_t'(pos_reg + 1'b1);
    assign pos_dec = usp_pkg::pos_t'(pos_reg - 1'b1);

    always_comb
    begin
        mode_next   = mode_reg;
        run_next    = run_reg;
        pres_next   = pres_reg;
        failed_next = failed_reg;
        for (int k = 0; k < usp_pkg::SPAN_COUNT; k++)
        begin
            start_next[k] = start_reg[k];
            len_next[k]   = len_reg[k];
        end
        do_auth = 1'b0;
        do_port = 1'b0;
        do_path = 1'b0;
        do_fail = 1'b0;

        if (pos_reg >= usp_pkg::pos_t'(usp_pkg::MAX_LEN))
        begin
            do_fail = 1'b1;
        end
        else if (!failed_reg)
        begin
            case (mode_reg)
                usp_pkg::MODE_SCHEME:
                begin
                    if (usp_pkg::is_alnum(text_byte) && !end_of_text)
                    begin
                        mode_next = usp_pkg::MODE_SCHEME;
                    end
                    else if ((text_byte == usp_pkg::CH_COLON) && !end_of_text)
                    begin
                        mode_next = usp_pkg::MODE_COLON;
                    end
                    else if (usp_pkg::is_alnum(text_byte) || (text_byte == usp_pkg::CH_COLON) ||
                             (text_byte == usp_pkg::CH_AT) || (text_byte == usp_pkg::CH_DOT))
                    begin
                        run_next  = '0;
                        mode_next = usp_pkg::MODE_AUTH;
                        do_auth   = 1'b1;
                    end
                    else if (text_byte == usp_pkg::CH_SLASH)
                    begin
                        run_next  = '0;
                        mode_next = usp_pkg::MODE_PATH;
                        do_path   = 1'b1;
                    end
                    else
                    begin
                        // odd byte: dropped, authority starts after it
                        run_next  = pos_inc;
                        mode_next = usp_pkg::MODE_AUTH;
                    end
                end
                usp_pkg::MODE_COLON:
                begin
                    if (text_byte == usp_pkg::CH_SLASH)
                    begin
                        start_next[usp_pkg::K_PROTOCOL] = '0;
                        len_next[usp_pkg::K_PROTOCOL]   = usp_pkg::span_len('0, pos_dec);
                        pres_next[usp_pkg::K_PROTOCOL]  = 1'b1;
                        mode_next = usp_pkg::MODE_SLASH;
                    end
                    else
                    begin
                        // the run was a host after all; port starts here
                        start_next[usp_pkg::K_HOST] = '0;
                        len_next[usp_pkg::K_HOST]   = usp_pkg::span_len('0, pos_dec);
                        pres_next[usp_pkg::K_HOST]  = 1'b1;
                        run_next  = pos_reg;
                        mode_next = usp_pkg::MODE_PORT;
                        do_port   = 1'b1;
                    end
                end
                usp_pkg::MODE_SLASH:
                begin
                    mode_next = usp_pkg::MODE_AUTH;
                    if (text_byte == usp_pkg::CH_SLASH)
                    begin
                        run_next = pos_inc;
                    end
                    else
                    begin
                        run_next = pos_reg;
                        do_auth  = 1'b1;
                    end
                end
                usp_pkg::MODE_AUTH: do_auth = 1'b1;
                usp_pkg::MODE_PORT: do_port = 1'b1;
                usp_pkg::MODE_PATH: do_path = 1'b1;
                default:            mode_next = mode_reg;
            endcase

            if (do_auth)
            begin
                if (usp_pkg::is_alnum(text_byte) || (text_byte == usp_pkg::CH_DOT))
                begin
                    if (end_of_text)
                    begin
                        start_next[usp_pkg::K_HOST] = run_next;
                        len_next[usp_pkg::K_HOST]   = usp_pkg::span_len(run_next, pos_inc);
                        pres_next[usp_pkg::K_HOST]  = 1'b1;
                    end
                end
                else if (text_byte == usp_pkg::CH_AT)
                begin
                    start_next[usp_pkg::K_USERINFO] = run_next;
                    len_next[usp_pkg::K_USERINFO]   = usp_pkg::span_len(run_next, pos_reg);
                    pres_next[usp_pkg::K_USERINFO]  = 1'b1;
                    run_next = pos_inc;
                end
                else if ((text_byte == usp_pkg::CH_COLON) || (text_byte == usp_pkg::CH_SLASH))
                begin
                    start_next[usp_pkg::K_HOST] = run_next;
                    len_next[usp_pkg::K_HOST]   = usp_pkg::span_len(run_next, pos_reg);
                    pres_next[usp_pkg::K_HOST]  = 1'b1;
                    run_next  = pos_inc;
                    mode_next = (text_byte == usp_pkg::CH_COLON) ? usp_pkg::MODE_PORT
                                                                 : usp_pkg::MODE_PATH;
                end
                else
                begin
                    do_fail = 1'b1;
                end
            end

            if (do_port)
            begin
                if (usp_pkg::is_digit(text_byte))
                begin
                    if (end_of_text)
                    begin
                        start_next[usp_pkg::K_PORT] = run_next;
                        len_next[usp_pkg::K_PORT]   = usp_pkg::span_len(run_next, pos_inc);
                        pres_next[usp_pkg::K_PORT]  = 1'b1;
                    end
                end
                else if (text_byte == usp_pkg::CH_SLASH)
                begin
                    start_next[usp_pkg::K_PORT] = run_next;
                    len_next[usp_pkg::K_PORT]   = usp_pkg::span_len(run_next, pos_reg);
                    pres_next[usp_pkg::K_PORT]  = 1'b1;
                    run_next  = pos_inc;
                    mode_next = usp_pkg::MODE_PATH;
                end
                else
                begin
                    do_fail = 1'b1;
                end
            end

            if (do_path && end_of_text)
            begin
                start_next[usp_pkg::K_RESOURCE] = run_next;
                len_next[usp_pkg::K_RESOURCE]   = usp_pkg::span_len(run_next, pos_inc);
                pres_next[usp_pkg::K_RESOURCE]  = 1'b1;
            end
        end

        if (do_fail)
        begin
            failed_next = 1'b1;
            mode_next   = usp_pkg::MODE_HALT;
        end

        pos_next = (pos_reg < usp_pkg::pos_t'(usp_pkg::MAX_LEN)) ? pos_inc : pos_reg;
    end

    // snapshot as it stands after this byte; absent spans read as zero
    always_comb
    begin
        for (int k = 0; k < usp_pkg::SPAN_COUNT; k++)
        begin
            snap.present[k] = pres_next[k];
            snap.start[k]   = pres_next[k] ? usp_pkg::to_start(start_next[k]) : '0;
            snap.length[k]  = pres_next[k] ? usp_pkg::to_len(len_next[k]) : '0;
        end
        snap.ok = !failed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= usp_pkg::MODE_SCHEME;
            pos_reg    <= '0;
            run_reg    <= '0;
            pres_reg   <= '0;
            failed_reg <= 1'b0;
            for (int k = 0; k < usp_pkg::SPAN_COUNT; k++)
            begin
                start_reg[k] <= '0;
                len_reg[k]   <= '0;
            end
        end
        else if (take)
        begin
            if (end_of_text)
            begin
                mode_reg   <= usp_pkg::MODE_SCHEME;
                pos_reg    <= '0;
                run_reg    <= '0;
                pres_reg   <= '0;
                failed_reg <= 1'b0;
                for (int k = 0; k < usp_pkg::SPAN_COUNT; k++)
                begin
                    start_reg[k] <= '0;
                    len_reg[k]   <= '0;
                end
            end
            else
            begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                run_reg    <= run_next;
                pres_reg   <= pres_next;
                failed_reg <= failed_next;
                for (int k = 0; k < usp_pkg::SPAN_COUNT; k++)
                begin
                    start_reg[k] <= start_next[k];
                    len_reg[k]   <= len_next[k];
                end
            end
        end
    end

endmodule

// File: src/usp_emit.sv
// Result stage: holds one finished parse and sends its six items in order.
module usp_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  usp_pkg::span_set_t snap_in,
    output logic               busy,
    output logic               done,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         field_kind,
    output logic               present,
    output logic [7:0]         span_start,
    output logic [8:0]         span_length,
    output logic               url_ok,
    output logic               final_item
);

    logic                          busy_reg, busy_next;
    logic [usp_pkg::KIND_W-1:0]    cnt_reg, cnt_next;
    usp_pkg::span_set_t            snap_reg;
    logic                          is_status;

    assign is_status = (cnt_reg == usp_pkg::K_STATUS);
    assign busy      = busy_reg;
    assign done      = busy_reg && !out_stall && is_status;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            busy_next = 1'b1;
            cnt_next  = usp_pkg::K_PROTOCOL;
        end
        else if (busy_reg && !out_stall)
        begin
            if (is_status)
                busy_next = 1'b0;
            else
                cnt_next = usp_pkg::KIND_W'(cnt_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= usp_pkg::K_PROTOCOL;
            snap_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            if (load)
                snap_reg <= snap_in;
        end
    end

    always_comb
    begin
        out_valid   = busy_reg;
        field_kind  = cnt_reg;
        url_ok      = snap_reg.ok;
        final_item  = is_status;
        present     = 1'b0;
        span_start  = '0;
        span_length = '0;
        if (!is_status)
        begin
            present     = snap_reg.present[cnt_reg];
            span_start  = snap_reg.start[cnt_reg];
            span_length = snap_reg.length[cnt_reg];
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg <= usp_pkg::K_STATUS))
        else $error("item counter past status");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!busy_reg || done))
        else $error("new parse loaded over one still sending");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !load) |=> !busy_reg)
        else $error("still busy after status transfer");

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !out_stall && !is_status && !load) |=>
            (busy_reg && (cnt_reg == usp_pkg::KIND_W'($past(cnt_reg) + 1'b1))))
        else $error("span items out of order");
`endif

endmodule

// File: src/url_span_parser.sv
// Top level of the URL span parser: byte input, six result items per URL.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  input   | in_valid / in_stall  | text_byte, end_of_text
//  output  | out_valid / out_stall| field_kind, present, span_start, span_length,
//          |                      | url_ok, final_item
//
// One byte is taken per cycle while in_stall is low; the parse step is a single
// pass of logic on the mode, position and span registers. The last byte of a
// URL copies the spans into the result stage, which sends five span items and a
// status item, one a cycle while out_stall is low. Bytes of the next URL keep
// flowing meanwhile; only its last byte waits (in_stall) while the previous
// result is still being sent.
// rst_n clears everything asynchronously; no clearing pass is needed.
module url_span_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] field_kind,
    output logic       present,
    output logic [7:0] span_start,
    output logic [8:0] span_length,
    output logic       url_ok,
    output logic       final_item
);

    usp_pkg::span_set_t snap;
    logic               in_take;
    logic               emit_busy;
    logic               emit_done;

    // a finishing byte needs the result stage free (or freeing this cycle)
    assign in_stall = emit_busy && end_of_text && !emit_done;
    assign in_take  = in_valid && !in_stall;

    usp_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (in_take),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .snap        (snap)
    );

    usp_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (in_take && end_of_text),
        .snap_in     (snap),
        .busy        (emit_busy),
        .done        (emit_done),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .field_kind  (field_kind),
        .present     (present),
        .span_start  (span_start),
        .span_length (span_length),
        .url_ok      (url_ok),
        .final_item  (final_item)
    );

endmodule
